// File: rtl/tpp_pkg.sv
// Shared types, constants and helper functions of the three-axis position controller.
package tpp_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int LimW     = DataW - 1;
  localparam int ProdW    = 2 * DataW + 1 - FracBits;
  localparam int CfgIdxW  = 4;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [DataW-1:0]        gain_t;
  typedef logic [LimW-1:0]         lim_t;
  typedef logic signed [ProdW-1:0] prod_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIN_KP      = 4'd0,
    REG_LIN_KI      = 4'd1,
    REG_LIN_KD      = 4'd2,
    REG_LIN_MAX_OUT = 4'd3,
    REG_ANG_KP      = 4'd4,
    REG_ANG_KI      = 4'd5,
    REG_ANG_KD      = 4'd6,
    REG_ANG_MAX_OUT = 4'd7
  } cfg_reg_e;

  localparam gain_t LinKpRst     = 32'd283705344;
  localparam gain_t LinKiRst     = 32'd262;
  localparam gain_t LinKdRst     = 32'd425984000;
  localparam lim_t  LinMaxOutRst = 31'd262144000;
  localparam gain_t AngKpRst     = 32'd32768;
  localparam gain_t AngKiRst     = 32'd0;
  localparam gain_t AngKdRst     = 32'd26214;
  localparam lim_t  AngMaxOutRst = 31'd6553600;

  localparam longint IntLimFull = longint'(10000) << FracBits;
  localparam longint S32Max     = 64'sd2147483647;
  localparam data_t  IntLim     = data_t'((IntLimFull > S32Max) ? S32Max : IntLimFull);
  localparam data_t  LinDead    = data_t'(((longint'(1) << FracBits) + 50) / 100);
  localparam data_t  AngDead    = data_t'(longint'(2) << FracBits);

  typedef struct packed {
    logic ld1;
    logic upd_prev;
    logic ld2;
    logic ld3;
    logic upd_integ;
  } stage_ctl_t;

  // Saturates a 33-bit signed difference to the 32-bit signed range.
  function automatic data_t sat_diff(logic signed [DataW:0] v);
    data_t r;
    if (v[DataW] != v[DataW-1]) begin
      r = v[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // Unsigned gain times signed value, scaled down with rounding toward minus infinity.
  function automatic prod_t gain_mul(gain_t g, data_t v);
    logic signed [2*DataW:0] p;
    p = $signed({1'b0, g}) * v;
    return p[2*DataW:FracBits];
  endfunction

endpackage

// File: rtl/tpp_if.sv
// Channel interfaces: control sample input, command output and register writes.
interface tpp_smp_if;
  logic          valid;
  logic          ready;
  tpp_pkg::data_t target_x;
  tpp_pkg::data_t target_y;
  tpp_pkg::data_t target_heading;
  tpp_pkg::data_t meas_x;
  tpp_pkg::data_t meas_y;
  tpp_pkg::data_t meas_heading;

  modport source (output valid, target_x, target_y, target_heading,
                  meas_x, meas_y, meas_heading, input ready);
  modport sink (input valid, target_x, target_y, target_heading,
                meas_x, meas_y, meas_heading, output ready);
endinterface

interface tpp_res_if;
  logic          valid;
  logic          ready;
  tpp_pkg::data_t speed_x;
  tpp_pkg::data_t speed_y_neg;
  tpp_pkg::data_t omega;

  modport source (output valid, speed_x, speed_y_neg, omega, input ready);
  modport sink (input valid, speed_x, speed_y_neg, omega, output ready);
endinterface

interface tpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tpp_pkg::CfgIdxW-1:0]    index;
  logic [tpp_pkg::DataW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/three_axis_position_pid.sv
// Top level of the three-axis positional PID controller with integral clamp and deadband.
//
// The smp_i channel carries one control sample per transaction: targets and measured
// values for x, y and heading in signed Q16.16. For each sample the res_o channel
// delivers exactly one transaction with speed_x, speed_y_neg and omega, in order.
// Gains and limits are written over cfg_i, register index per the cfg_reg_e list;
// writes to other indexes are dropped. Writes are meant for times with no sample
// in flight, and cfg_i is always ready.
// A sample passes an input register, three internal stages and the output register.
// Every stage advances independently, so a new sample is taken every cycle unless res_o
// stalls and all the registers are occupied: throughput is one per cycle.
// The integral update is a feedback loop through integ_q in the third stage, the gain multipliers
// occupy the second stage.
// When res_o stalls, the output register holds its transaction and the stages behind
// it keep filling; smp_i.ready falls only once all five registers are occupied.
// Reset restores the default gains and limits and clears the previous errors and
// integrals of all three axes, and empties the pipeline.
module three_axis_position_pid (
  input  logic      clk_i,
  input  logic      rst_ni,
  tpp_smp_if.sink   smp_i,
  tpp_res_if.source res_o,
  tpp_cfg_if.sink   cfg_i
);

  tpp_pkg::gain_t lin_kp_q, lin_ki_q, lin_kd_q;
  tpp_pkg::gain_t ang_kp_q, ang_ki_q, ang_kd_q;
  tpp_pkg::lim_t  lin_max_out_q, ang_max_out_q;

  tpp_pkg::data_t tgt_x_q, tgt_y_q, tgt_h_q;
  tpp_pkg::data_t meas_x_q, meas_y_q, meas_h_q;

  logic [3:0] vld_q;
  logic [3:0] rdy;
  logic       rdy_out;
  logic       out_vld_q;

  tpp_pkg::stage_ctl_t ctl;
  tpp_pkg::data_t      cmd_x, cmd_y, cmd_h;
  tpp_pkg::data_t      speed_x_q, speed_y_neg_q, omega_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_kp_q      <= tpp_pkg::LinKpRst;
      lin_ki_q      <= tpp_pkg::LinKiRst;
      lin_kd_q      <= tpp_pkg::LinKdRst;
      lin_max_out_q <= tpp_pkg::LinMaxOutRst;
      ang_kp_q      <= tpp_pkg::AngKpRst;
      ang_ki_q      <= tpp_pkg::AngKiRst;
      ang_kd_q      <= tpp_pkg::AngKdRst;
      ang_max_out_q <= tpp_pkg::AngMaxOutRst;
    end else if (cfg_i.valid) begin
      case (tpp_pkg::cfg_reg_e'(cfg_i.index))
        tpp_pkg::REG_LIN_KP:      lin_kp_q      <= cfg_i.data;
        tpp_pkg::REG_LIN_KI:      lin_ki_q      <= cfg_i.data;
        tpp_pkg::REG_LIN_KD:      lin_kd_q      <= cfg_i.data;
        tpp_pkg::REG_LIN_MAX_OUT: lin_max_out_q <= cfg_i.data[tpp_pkg::LimW-1:0];
        tpp_pkg::REG_ANG_KP:      ang_kp_q      <= cfg_i.data;
        tpp_pkg::REG_ANG_KI:      ang_ki_q      <= cfg_i.data;
        tpp_pkg::REG_ANG_KD:      ang_kd_q      <= cfg_i.data;
        tpp_pkg::REG_ANG_MAX_OUT: ang_max_out_q <= cfg_i.data[tpp_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy_out = !out_vld_q || res_o.ready;
    rdy[3]  = !vld_q[3] || rdy_out;
    rdy[2]  = !vld_q[2] || rdy[3];
    rdy[1]  = !vld_q[1] || rdy[2];
    rdy[0]  = !vld_q[0] || rdy[1];

    ctl.ld1       = rdy[1];
    ctl.upd_prev  = vld_q[0] && rdy[1];
    ctl.ld2       = rdy[2];
    ctl.ld3       = rdy[3];
    ctl.upd_integ = vld_q[2] && rdy[3];
  end

  assign smp_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= smp_i.valid;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
      if (rdy[2]) begin
        vld_q[2] <= vld_q[1];
      end
      if (rdy[3]) begin
        vld_q[3] <= vld_q[2];
      end
      if (rdy_out) begin
        out_vld_q <= vld_q[3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && smp_i.valid) begin
      tgt_x_q  <= smp_i.target_x;
      tgt_y_q  <= smp_i.target_y;
      tgt_h_q  <= smp_i.target_heading;
      meas_x_q <= smp_i.meas_x;
      meas_y_q <= smp_i.meas_y;
      meas_h_q <= smp_i.meas_heading;
    end
  end

  tpp_axis u_axis_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .target_i  (tgt_x_q),
    .meas_i    (meas_x_q),
    .kp_i      (lin_kp_q),
    .ki_i      (lin_ki_q),
    .kd_i      (lin_kd_q),
    .max_out_i (lin_max_out_q),
    .dead_i    (tpp_pkg::LinDead),
    .cmd_o     (cmd_x)
  );

  tpp_axis u_axis_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .target_i  (tgt_y_q),
    .meas_i    (meas_y_q),
    .kp_i      (lin_kp_q),
    .ki_i      (lin_ki_q),
    .kd_i      (lin_kd_q),
    .max_out_i (lin_max_out_q),
    .dead_i    (tpp_pkg::LinDead),
    .cmd_o     (cmd_y)
  );

  tpp_axis u_axis_h (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .target_i  (tgt_h_q),
    .meas_i    (meas_h_q),
    .kp_i      (ang_kp_q),
    .ki_i      (ang_ki_q),
    .kd_i      (ang_kd_q),
    .max_out_i (ang_max_out_q),
    .dead_i    (tpp_pkg::AngDead),
    .cmd_o     (cmd_h)
  );

  always_ff @(posedge clk_i) begin
    if (rdy_out && vld_q[3]) begin
      speed_x_q     <= cmd_x;
      speed_y_neg_q <= -cmd_y;
      omega_q       <= cmd_h;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.speed_x     = speed_x_q;
  assign res_o.speed_y_neg = speed_y_neg_q;
  assign res_o.omega       = omega_q;

endmodule

// File: rtl/tpp_axis.sv
// One controller axis: error, derivative, deadband, gain products, clamped integral and output clamp.
module tpp_axis (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpp_pkg::stage_ctl_t ctl_i,
  input  tpp_pkg::data_t      target_i,
  input  tpp_pkg::data_t      meas_i,
  input  tpp_pkg::gain_t      kp_i,
  input  tpp_pkg::gain_t      ki_i,
  input  tpp_pkg::gain_t      kd_i,
  input  tpp_pkg::lim_t       max_out_i,
  input  tpp_pkg::data_t      dead_i,
  output tpp_pkg::data_t      cmd_o
);

  localparam int DW = tpp_pkg::DataW;
  localparam int PW = tpp_pkg::ProdW;

  tpp_pkg::data_t err;
  tpp_pkg::data_t diff;
  logic [DW:0]    mag;
  logic           in_dead;

  tpp_pkg::data_t prev_q;
  tpp_pkg::data_t err_q;
  tpp_pkg::data_t diff_q;
  logic           dead1_q;

  tpp_pkg::prod_t pi_q;
  tpp_pkg::prod_t pp_q;
  tpp_pkg::prod_t pd_q;
  logic           dead2_q;

  logic signed [PW:0] isum;
  logic signed [PW:0] ilim;
  tpp_pkg::data_t     integ_d;
  tpp_pkg::data_t     integ_q;
  tpp_pkg::data_t     integ3_q;
  logic signed [PW:0] ppd;
  logic signed [PW:0] ppd_q;
  logic               dead3_q;

  logic signed [PW+1:0] sum;
  logic signed [PW+1:0] olim;

  always_comb begin
    err = tpp_pkg::sat_diff($signed({target_i[DW-1], target_i}) -
                            $signed({meas_i[DW-1], meas_i}));
    diff = tpp_pkg::sat_diff($signed({err[DW-1], err}) - $signed({prev_q[DW-1], prev_q}));
    mag = err[DW-1] ? (-{err[DW-1], err}) : {err[DW-1], err};
    in_dead = mag < {1'b0, dead_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctl_i.upd_prev) begin
      prev_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      err_q   <= err;
      diff_q  <= diff;
      dead1_q <= in_dead;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      pi_q    <= tpp_pkg::gain_mul(ki_i, err_q);
      pp_q    <= tpp_pkg::gain_mul(kp_i, err_q);
      pd_q    <= tpp_pkg::gain_mul(kd_i, diff_q);
      dead2_q <= dead1_q;
    end
  end

  always_comb begin
    isum = $signed({{(PW+1-DW){integ_q[DW-1]}}, integ_q}) + $signed({pi_q[PW-1], pi_q});
    ilim = $signed({{(PW+1-DW){1'b0}}, tpp_pkg::IntLim});
    if (isum > ilim) begin
      integ_d = tpp_pkg::IntLim;
    end else if (isum < -ilim) begin
      integ_d = -tpp_pkg::IntLim;
    end else begin
      integ_d = isum[DW-1:0];
    end
    ppd = $signed({pp_q[PW-1], pp_q}) + $signed({pd_q[PW-1], pd_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctl_i.upd_integ) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      integ3_q <= integ_d;
      ppd_q    <= ppd;
      dead3_q  <= dead2_q;
    end
  end

  always_comb begin
    sum  = $signed({{(PW+2-DW){integ3_q[DW-1]}}, integ3_q}) + $signed({ppd_q[PW], ppd_q});
    olim = $signed({{(PW+2-(DW-1)){1'b0}}, max_out_i});
    if (dead3_q) begin
      cmd_o = '0;
    end else if (sum > olim) begin
      cmd_o = olim[DW-1:0];
    end else if (sum < -olim) begin
      cmd_o = -olim[DW-1:0];
    end else begin
      cmd_o = sum[DW-1:0];
    end
  end

endmodule

// File: rtl/tpp_checker.sv
// Port-level checker for the three-axis position controller and its bind statement.
module tpp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input tpp_pkg::data_t speed_x_i,
  input tpp_pkg::data_t speed_y_neg_i,
  input tpp_pkg::data_t omega_i
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Number of samples taken whose result has not been delivered yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cnt_q != 3'd0))
    else $error("result shown with no sample outstanding");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd0) |-> in_ready_i)
    else $error("input not ready although no sample is in flight");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cnt_q == 3'd0) |-> ##5 out_valid_i)
    else $error("result of a lone sample did not arrive after five cycles");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(speed_x_i) && $stable(speed_y_neg_i) && $stable(omega_i)))
    else $error("stalled result transaction changed");

endmodule

bind three_axis_position_pid tpp_checker u_tpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (smp_i.valid),
  .in_ready_i    (smp_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .speed_x_i     (res_o.speed_x),
  .speed_y_neg_i (res_o.speed_y_neg),
  .omega_i       (res_o.omega)
);

// File: tb/sv/three_axis_position_pid_checker.sv
// Checker for the three-axis position controller: predicts each command and compares it.
module three_axis_position_pid_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tpp_smp_if   smp_i,
  tpp_res_if   res_i,
  tpp_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tpp_pkg::data_t speed_x;
    tpp_pkg::data_t speed_y_neg;
    tpp_pkg::data_t omega;
  } cmd_t;

  localparam longint WordHi   = 64'sd2147483647;
  localparam longint WordLo   = -64'sd2147483648;
  localparam longint IntFull  = longint'(10000) << tpp_pkg::FracBits;
  localparam longint IntClamp = (IntFull > WordHi) ? WordHi : IntFull;
  localparam longint LinBand  = ((longint'(1) << tpp_pkg::FracBits) + 50) / 100;
  localparam longint AngBand  = longint'(2) << tpp_pkg::FracBits;

  tpp_pkg::gain_t lin_kp, lin_ki, lin_kd, ang_kp, ang_ki, ang_kd;
  tpp_pkg::lim_t  lin_lim, ang_lim;
  longint         integ_acc [3];
  longint         err_hist [3];
  cmd_t           expected_cmds [$];
  int             n_fail = 0;

  function automatic longint sat_word(longint v);
    if (v > WordHi) return WordHi;
    if (v < WordLo) return WordLo;
    return v;
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint scaled_product(tpp_pkg::gain_t g, longint v);
    longint p;
    p = longint'({32'd0, g}) * v;
    return p >>> tpp_pkg::FracBits;
  endfunction

  function automatic longint pid_axis_step(int ax, longint err, tpp_pkg::gain_t kp,
                                           tpp_pkg::gain_t ki, tpp_pkg::gain_t kd,
                                           tpp_pkg::lim_t lim, longint band);
    longint diff;
    longint sum;
    integ_acc[ax] = clamp_mag(integ_acc[ax] + scaled_product(ki, err), IntClamp);
    diff = sat_word(err - err_hist[ax]);
    sum = integ_acc[ax] + scaled_product(kp, err) + scaled_product(kd, diff);
    sum = clamp_mag(sum, longint'(lim));
    err_hist[ax] = err;
    if (((err < 0) ? -err : err) < band) return 0;
    return sum;
  endfunction

  function automatic cmd_t predict_commands(input tpp_pkg::data_t tx, ty, th, mx, my, mh);
    cmd_t   c;
    longint sx;
    longint sy;
    longint om;
    sx = pid_axis_step(0, sat_word(longint'(tx) - longint'(mx)),
                       lin_kp, lin_ki, lin_kd, lin_lim, LinBand);
    sy = pid_axis_step(1, sat_word(longint'(ty) - longint'(my)),
                       lin_kp, lin_ki, lin_kd, lin_lim, LinBand);
    om = pid_axis_step(2, sat_word(longint'(th) - longint'(mh)),
                       ang_kp, ang_ki, ang_kd, ang_lim, AngBand);
    c.speed_x     = tpp_pkg::data_t'(sx);
    c.speed_y_neg = tpp_pkg::data_t'(-sy);
    c.omega       = tpp_pkg::data_t'(om);
    return c;
  endfunction

  task automatic check_field(string field, tpp_pkg::data_t want, tpp_pkg::data_t got);
    if (got !== want) begin
      if (n_fail < 10) begin
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
      end
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t got;
    cmd_t want;
    if (!rst_ni) begin
      lin_kp    = 32'd283705344;
      lin_ki    = 32'd262;
      lin_kd    = 32'd425984000;
      lin_lim   = 31'd262144000;
      ang_kp    = 32'd32768;
      ang_ki    = 32'd0;
      ang_kd    = 32'd26214;
      ang_lim   = 31'd6553600;
      integ_acc = '{default: 0};
      err_hist  = '{default: 0};
      expected_cmds.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          tpp_pkg::REG_LIN_KP:      lin_kp = cfg_i.data;
          tpp_pkg::REG_LIN_KI:      lin_ki = cfg_i.data;
          tpp_pkg::REG_LIN_KD:      lin_kd = cfg_i.data;
          tpp_pkg::REG_LIN_MAX_OUT: lin_lim = tpp_pkg::lim_t'(cfg_i.data);
          tpp_pkg::REG_ANG_KP:      ang_kp = cfg_i.data;
          tpp_pkg::REG_ANG_KI:      ang_ki = cfg_i.data;
          tpp_pkg::REG_ANG_KD:      ang_kd = cfg_i.data;
          tpp_pkg::REG_ANG_MAX_OUT: ang_lim = tpp_pkg::lim_t'(cfg_i.data);
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.speed_x, res_i.speed_y_neg, res_i.omega};
        if (expected_cmds.size() == 0) begin
          if (n_fail < 10) begin
            $display("%0t: command transaction with none expected: %0d %0d %0d",
                     $realtime, got.speed_x, got.speed_y_neg, got.omega);
          end
          n_fail++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("speed_x", want.speed_x, got.speed_x);
          check_field("speed_y_neg", want.speed_y_neg, got.speed_y_neg);
          check_field("omega", want.omega, got.omega);
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        expected_cmds.push_back(predict_commands(smp_i.target_x, smp_i.target_y,
                                                 smp_i.target_heading, smp_i.meas_x,
                                                 smp_i.meas_y, smp_i.meas_heading));
      end
      pending_o <= expected_cmds.size();
    end
  end

  assign fail_count_o = n_fail;

endmodule

// File: tb/sv/three_axis_position_pid_tb.sv
// Testbench top for the three-axis position controller: clock, reset, stimulus and verdict.
module three_axis_position_pid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int             HoldCycles  = 64;
  localparam int             DrainCycles = 16;
  localparam int             PhaseItems  = 300;
  localparam int             IdxW        = tpp_pkg::CfgIdxW;
  localparam tpp_pkg::data_t WordMax     = 32'sh7fffffff;
  localparam tpp_pkg::data_t WordMin     = 32'sh80000000;
  localparam tpp_pkg::data_t LinBandW    =
    tpp_pkg::data_t'(((longint'(1) << tpp_pkg::FracBits) + 50) / 100);
  localparam tpp_pkg::data_t AngBandW    = tpp_pkg::data_t'(longint'(2) << tpp_pkg::FracBits);
  localparam tpp_pkg::gain_t PowerOnRegs [8] = '{32'd283705344, 32'd262, 32'd425984000,
                                                 32'd262144000, 32'd32768, 32'd0, 32'd26214,
                                                 32'd6553600};

  typedef struct packed {
    tpp_pkg::data_t target_x;
    tpp_pkg::data_t target_y;
    tpp_pkg::data_t target_heading;
    tpp_pkg::data_t meas_x;
    tpp_pkg::data_t meas_y;
    tpp_pkg::data_t meas_heading;
  } sample_t;

  logic clk;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   tx_idle_pct = 36;
  int   rx_idle_pct = 87;
  int   rx_hold_asks = 0;
  int   rx_hold_served = 0;

  tpp_smp_if smp_if ();
  tpp_res_if res_if ();
  tpp_cfg_if cfg_if ();

  three_axis_position_pid i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  three_axis_position_pid_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .smp_i        (smp_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_asks != rx_hold_served) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        rx_hold_served <= rx_hold_served + 1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic tpp_pkg::data_t extreme_word();
    case ($urandom_range(3))
      0:       return WordMax;
      1:       return WordMin;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic void pick_axis(input tpp_pkg::data_t band, output tpp_pkg::data_t t,
                                    output tpp_pkg::data_t m);
    tpp_pkg::data_t delta;
    t = $urandom;
    case ($urandom_range(9))
      0, 1, 2: m = $urandom;
      3, 4, 5: begin
        delta = tpp_pkg::data_t'(longint'($urandom_range(2 * band + 2)) - band - 1);
        m = t - delta;
      end
      6: begin
        t = extreme_word();
        m = extreme_word();
      end
      default: begin
        t = tpp_pkg::data_t'(longint'($urandom_range(1 << 21)) - (1 << 20));
        m = tpp_pkg::data_t'(longint'($urandom_range(1 << 21)) - (1 << 20));
      end
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    pick_axis(LinBandW, s.target_x, s.meas_x);
    pick_axis(LinBandW, s.target_y, s.meas_y);
    pick_axis(AngBandW, s.target_heading, s.meas_heading);
    return s;
  endfunction

  function automatic void pick_config(input int phase_no, output tpp_pkg::gain_t v [8]);
    for (int r = 0; r < 8; r++) begin
      case (phase_no)
        0: v[r] = $urandom;
        1: v[r] = '1;
        2: v[r] = '0;
        3: begin
          if (r == tpp_pkg::REG_LIN_MAX_OUT || r == tpp_pkg::REG_ANG_MAX_OUT) begin
            v[r] = $urandom;
          end else begin
            v[r] = $urandom_range(1 << 22);
          end
        end
        4: v[r] = (r == tpp_pkg::REG_ANG_KI) ? 32'd65536 : PowerOnRegs[r];
        default: begin
          case ($urandom_range(3))
            0:       v[r] = '0;
            1:       v[r] = '1;
            2:       v[r] = $urandom;
            default: v[r] = $urandom_range(1 << 20);
          endcase
        end
      endcase
    end
  endfunction

  task automatic send(input sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid          <= 1'b1;
    smp_if.target_x       <= s.target_x;
    smp_if.target_y       <= s.target_y;
    smp_if.target_heading <= s.target_heading;
    smp_if.meas_x         <= s.meas_x;
    smp_if.meas_y         <= s.meas_y;
    smp_if.meas_heading   <= s.meas_heading;
    do @(posedge clk); while (!smp_if.ready);
  endtask

  task automatic write_config(input tpp_pkg::gain_t v [8]);
    for (int r = 0; r < 8; r++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= tpp_pkg::cfg_reg_e'(r);
      cfg_if.data  <= v[r];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.index <= IdxW'($urandom_range(15, tpp_pkg::REG_ANG_MAX_OUT + 1));
    cfg_if.data  <= $urandom;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    smp_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin
    tpp_pkg::gain_t regs [8];
    smp_if.valid          = 1'b0;
    smp_if.target_x       = '0;
    smp_if.target_y       = '0;
    smp_if.target_heading = '0;
    smp_if.meas_x         = '0;
    smp_if.meas_y         = '0;
    smp_if.meas_heading   = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-on gains: deadband edges, saturating errors and error steps.
    send('{0, 0, 0, 0, 0, 0});
    send('{LinBandW, LinBandW - 1, AngBandW, 0, 0, 0});
    send('{0, 0, 0, LinBandW, LinBandW - 1, AngBandW - 1});
    send('{0, 0, 0, LinBandW - 1, LinBandW, AngBandW});
    send('{WordMax, WordMin, WordMax, WordMin, WordMax, WordMin});
    send('{WordMin, WordMax, WordMin, WordMax, WordMin, WordMax});
    send('{WordMax, WordMin, WordMax, WordMin, WordMax, WordMin});
    send('{WordMax, WordMax, WordMin, WordMax, WordMax, WordMin});
    send('{0, WordMin, 0, WordMin, 0, WordMax});
    repeat (6) send('{WordMax, WordMin, tpp_pkg::data_t'(100 << tpp_pkg::FracBits), 0, 0, 0});
    send('{-1, 1, -1, 0, 0, 0});

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      if (ph < 2) begin
        tx_idle_pct = 36;
        rx_idle_pct <= 87;
      end else if (ph < 4) begin
        tx_idle_pct = 87;
        rx_idle_pct <= 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      pick_config(ph, regs);
      write_config(regs);
      if (ph >= 4) begin
        rx_hold_asks <= rx_hold_asks + 1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == PhaseItems / 2) begin
          drain();
        end
        send(rand_sample());
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
